// ===== src/sevc_pkg.sv =====
// Package for the streaming edge vertex clustering block.
// Holds the shared types, operation codes and constants. No dependencies.
`timescale 1ns / 1ps

package sevc_pkg;

   localparam int unsigned NUM_VERTICES = 65536;
   localparam int unsigned VTX_W = $clog2(NUM_VERTICES);
   localparam int unsigned CL_W = 17;
   localparam int unsigned WORD_W = 32;
   localparam logic [WORD_W-1:0] WORD_MAX = '1;
   localparam logic [CL_W-1:0] CL_NONE = '1;
   localparam logic [VTX_W:0] LAST_ID = (VTX_W+1)'(NUM_VERTICES - 1);

   typedef enum logic [1:0] {
      OP_DEGREE  = 2'd0,
      OP_CLUSTER = 2'd1,
      OP_READ    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      CSR_THRESHOLD  = 1'b0,
      CSR_MAX_VOLUME = 1'b1
   } csr_idx_type;

   // Controller sequence. The steps between ST_IDLE and ST_RESP each drive one datapath round.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_VTX,
      ST_WR_DEG,
      ST_ASSIGN,
      ST_RD_VOL,
      ST_MOVE,
      ST_WR_MOVE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic rd_vtx;
      logic wr_deg;
      logic assign_ids;
      logic rd_vol;
      logic move;
      logic wr_move;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic is_degree;
      logic is_cluster;
   } status_type;

   function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
      logic [WORD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WORD_W] ? WORD_MAX : s[WORD_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] sat_sub(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
      return (a > b) ? a - b : '0;
   endfunction

endpackage

// ===== src/sevc_ctrl.sv =====
// Controller state machine of the edge vertex clustering block.
// Depends on sevc_pkg for the state, command and status types.
`timescale 1ns / 1ps

module sevc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sevc_pkg::status_type status,
   output sevc_pkg::cmd_type    cmd
);

   sevc_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sevc_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         sevc_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) state_in = sevc_pkg::ST_IDLE;
         end
         sevc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = sevc_pkg::ST_RD_VTX;
            end
         end
         sevc_pkg::ST_RD_VTX: begin
            cmd.rd_vtx = 1'b1;
            if (status.is_degree) state_in = sevc_pkg::ST_WR_DEG;
            else if (status.is_cluster) state_in = sevc_pkg::ST_ASSIGN;
            else state_in = sevc_pkg::ST_RESP;
         end
         sevc_pkg::ST_WR_DEG: begin
            cmd.wr_deg = 1'b1;
            state_in   = sevc_pkg::ST_RESP;
         end
         sevc_pkg::ST_ASSIGN: begin
            cmd.assign_ids = 1'b1;
            state_in       = sevc_pkg::ST_RD_VOL;
         end
         sevc_pkg::ST_RD_VOL: begin
            cmd.rd_vol = 1'b1;
            state_in   = sevc_pkg::ST_MOVE;
         end
         sevc_pkg::ST_MOVE: begin
            cmd.move = 1'b1;
            state_in = sevc_pkg::ST_WR_MOVE;
         end
         sevc_pkg::ST_WR_MOVE: begin
            cmd.wr_move = 1'b1;
            state_in    = sevc_pkg::ST_RESP;
         end
         sevc_pkg::ST_RESP: begin
            // Wait until the output register is free before loading it.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = sevc_pkg::ST_IDLE;
            end
         end
         default: state_in = sevc_pkg::ST_IDLE;
      endcase
   end

endmodule

// ===== src/sevc_datapath.sv =====
// Datapath of the edge vertex clustering block: vertex and cluster tables,
// move arithmetic and the result register. Depends on sevc_pkg.
`timescale 1ns / 1ps

module sevc_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  sevc_pkg::cmd_type               cmd,
   output sevc_pkg::status_type            status,
   input  logic [1:0]                      req_operation,
   input  logic [15:0]                     req_src_vertex,
   input  logic [15:0]                     req_dst_vertex,
   input  logic                            csr_write,
   input  logic                            csr_index,
   input  logic [sevc_pkg::WORD_W-1:0]     csr_data,
   output logic                            rsp_edge_is_head,
   output logic signed [sevc_pkg::CL_W-1:0] rsp_src_cluster,
   output logic signed [sevc_pkg::CL_W-1:0] rsp_dst_cluster,
   output logic signed [sevc_pkg::CL_W-1:0] rsp_read_head_cluster,
   output logic signed [sevc_pkg::CL_W-1:0] rsp_read_tail_cluster,
   output logic [sevc_pkg::WORD_W-1:0]     rsp_read_degree
);

   localparam int unsigned VW = sevc_pkg::VTX_W;
   localparam int unsigned WW = sevc_pkg::WORD_W;
   localparam int unsigned CW = sevc_pkg::CL_W;

   // Per-vertex record and per-cluster record, each one wide memory.
   typedef struct packed {
      logic [WW-1:0] degree;
      logic [WW-1:0] tail_degree;
      logic [CW-1:0] head_cl;
      logic [CW-1:0] tail_cl;
   } vrec_type;

   typedef struct packed {
      logic [WW-1:0] head_vol;
      logic [WW-1:0] tail_vol;
   } crec_type;

   vrec_type vmem [sevc_pkg::NUM_VERTICES];
   crec_type cmem [sevc_pkg::NUM_VERTICES];

   logic [WW-1:0] thr_ff, maxv_ff;
   logic [VW:0]   clr_ff;
   logic [VW:0]   nh_ff, nt_ff;
   logic [1:0]    op_ff;
   logic          inr_ff;
   logic [VW-1:0] s_ff, d_ff;
   logic          head_ff;
   vrec_type      vs_ff, vd_ff;
   crec_type      cs_ff, cd_ff;
   crec_type      cs_in, cd_in;
   logic          mv_ff, mv_src_ff;
   logic [VW-1:0] cs_a_ff, cd_a_ff;
   logic          same_c_ff;

   logic [VW-1:0] vs_addr, vd_addr;
   vrec_type      vs_rd_ff, vd_rd_ff;
   crec_type      cs_rd_ff, cd_rd_ff;
   logic [VW-1:0] cs_addr, cd_addr;

   // Write ports.
   logic          vwa_en, vwb_en, cwa_en, cwb_en;
   logic [VW-1:0] vwa_addr, vwb_addr, cwa_addr, cwb_addr;
   vrec_type      vwa_data, vwb_data;
   crec_type      cwa_data, cwb_data;

   assign status.clear_done = clr_ff[VW];
   assign status.is_degree  = (op_ff == sevc_pkg::OP_DEGREE) && inr_ff;
   assign status.is_cluster = (op_ff == sevc_pkg::OP_CLUSTER) && inr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= '0;
         maxv_ff <= sevc_pkg::WORD_MAX;
      end else if (csr_write) begin
         if (csr_index == sevc_pkg::CSR_THRESHOLD) thr_ff <= csr_data;
         else maxv_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear && !clr_ff[VW]) clr_ff <= clr_ff + 1'b1;
   end

   // Capture the transaction.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_operation;
         s_ff   <= req_src_vertex[VW-1:0];
         d_ff   <= req_dst_vertex[VW-1:0];
         inr_ff <= ({16'd0, req_src_vertex} < 32'(sevc_pkg::NUM_VERTICES)) &&
                   (({16'd0, req_dst_vertex} < 32'(sevc_pkg::NUM_VERTICES)) ||
                    req_operation == sevc_pkg::OP_READ);
      end
   end

   // Memory reads are registered; vertex addresses come from the request on capture, else from the held vertices.
   assign vs_addr = cmd.capture ? req_src_vertex[VW-1:0] : s_ff;
   assign vd_addr = cmd.capture ? req_dst_vertex[VW-1:0] : d_ff;

   always_ff @(posedge clock) begin
      vs_rd_ff <= vmem[vs_addr];
      vd_rd_ff <= vmem[vd_addr];
      cs_rd_ff <= cmem[cs_addr];
      cd_rd_ff <= cmem[cd_addr];
   end

   always_ff @(posedge clock) begin
      if (vwa_en) vmem[vwa_addr] <= vwa_data;
      if (vwb_en) vmem[vwb_addr] <= vwb_data;
   end

   always_ff @(posedge clock) begin
      if (cwa_en) cmem[cwa_addr] <= cwa_data;
      if (cwb_en) cmem[cwb_addr] <= cwb_data;
   end

   function automatic logic [VW-1:0] cid(input logic [CW-1:0] c);
      return (c[CW-1] || {1'b0, c} >= (CW+1)'(sevc_pkg::NUM_VERTICES)) ? '0 : c[VW-1:0];
   endfunction

   // Fresh id generation for one or two endpoints at once.
   logic          need_s, need_d, same_v;
   logic [VW:0]   id_s, id_d, nxt_cnt;
   logic [VW:0]   cnt_base;
   logic          head_sel;
   logic [CW-1:0] cl_s_cur, cl_d_cur;

   always_comb begin
      head_sel = (vs_rd_ff.degree >= thr_ff) && (vd_rd_ff.degree >= thr_ff);
      cl_s_cur = head_ff ? vs_ff.head_cl : vs_ff.tail_cl;
      cl_d_cur = head_ff ? vd_ff.head_cl : vd_ff.tail_cl;
      cnt_base = head_ff ? nh_ff : nt_ff;
      same_v   = (s_ff == d_ff);
      need_s   = cl_s_cur[CW-1];
      need_d   = cl_d_cur[CW-1] && !same_v;
      id_s     = cnt_base;
      nxt_cnt  = cnt_base;
      if (need_s) begin
         if (cnt_base >= sevc_pkg::LAST_ID + 1'b1) id_s = sevc_pkg::LAST_ID;
         else nxt_cnt = cnt_base + 1'b1;
      end
      id_d = nxt_cnt;
      if (need_d) begin
         if (nxt_cnt >= sevc_pkg::LAST_ID + 1'b1) id_d = sevc_pkg::LAST_ID;
         else nxt_cnt = nxt_cnt + 1'b1;
      end
   end

   // Cluster addresses come from the vertex records held in vs_ff, vd_ff. While
   // ids are being assigned, the cluster reads already use the fresh ids.
   logic [CW-1:0] cls, cld;
   always_comb begin
      cls = cl_s_cur;
      cld = cl_d_cur;
      if (cmd.assign_ids) begin
         if (need_s) cls = CW'(id_s);
         if (need_d) cld = CW'(id_d);
         else if (same_v && need_s) cld = CW'(id_s);
      end
   end
   assign cs_addr = cid(cls);
   assign cd_addr = cid(cld);

   // Move decision (registered volumes in cs_ff, cd_ff after the rd_vol step).
   logic              same_c;
   logic signed [WW+1:0] rs, rd;
   logic [WW:0]       sum_sd, sum_ds;
   logic              h_src, h_dst, t_ok, t_src, t_move;
   logic [WW-1:0]     t_deg;
   logic [WW:0]       t_sum;

   always_comb begin
      same_c = (cs_addr == cd_addr);
      rs     = $signed({2'b00, cs_ff.head_vol}) - $signed({2'b00, vs_ff.degree});
      rd     = $signed({2'b00, cd_ff.head_vol}) - $signed({2'b00, vd_ff.degree});
      sum_sd = {1'b0, cd_ff.head_vol} + {1'b0, vs_ff.degree};
      sum_ds = {1'b0, cs_ff.head_vol} + {1'b0, vd_ff.degree};
      h_src  = (rs <= rd) && (sum_sd <= {1'b0, maxv_ff});
      h_dst  = !h_src && (rd <= rs) && (sum_ds <= {1'b0, maxv_ff});
      t_ok   = (cs_ff.tail_vol < maxv_ff) && (cd_ff.tail_vol < maxv_ff);
      t_src  = cs_ff.tail_vol < cd_ff.tail_vol;
      t_deg  = t_src ? vs_ff.tail_degree : vd_ff.tail_degree;
      t_sum  = {1'b0, (t_src ? cd_ff.tail_vol : cs_ff.tail_vol)} + {1'b0, t_deg};
      t_move = t_ok && (t_sum <= {1'b0, maxv_ff});
   end

   always_comb begin
      vwa_en   = 1'b0;
      vwb_en   = 1'b0;
      vwa_addr = s_ff;
      vwb_addr = d_ff;
      vwa_data = vs_ff;
      vwb_data = vd_ff;
      cwa_en   = 1'b0;
      cwb_en   = 1'b0;
      cwa_addr = cs_a_ff;
      cwb_addr = cd_a_ff;
      cwa_data = cs_ff;
      cwb_data = cd_ff;
      if (cmd.clear) begin
         vwa_en   = !clr_ff[VW];
         vwa_addr = clr_ff[VW-1:0];
         vwa_data = '{degree: '0, tail_degree: '0,
                      head_cl: sevc_pkg::CL_NONE, tail_cl: sevc_pkg::CL_NONE};
         cwa_en   = !clr_ff[VW];
         cwa_addr = clr_ff[VW-1:0];
         cwa_data = '0;
      end else if (cmd.wr_deg) begin
         if (same_v) begin
            vwa_en = 1'b1;
            vwa_data.degree = sevc_pkg::sat_add(vs_ff.degree, WW'(2));
         end else begin
            vwa_en = 1'b1;
            vwb_en = 1'b1;
            vwa_data.degree = sevc_pkg::sat_add(vs_ff.degree, WW'(1));
            vwb_data.degree = sevc_pkg::sat_add(vd_ff.degree, WW'(1));
         end
      end else if (cmd.wr_move) begin
         // The cluster addresses were latched before the move changed the ids.
         cwa_en = 1'b1;
         cwb_en = !same_c_ff;
         vwa_en = 1'b1;
         vwb_en = !same_v;
         if (same_v) vwa_data = vs_ff;
         cwa_data = cs_ff;
         cwb_data = cd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nh_ff <= '0;
         nt_ff <= '0;
      end else if (cmd.assign_ids) begin
         if (head_ff) nh_ff <= nxt_cnt;
         else nt_ff <= nxt_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_vtx) begin
         vs_ff   <= vs_rd_ff;
         vd_ff   <= vd_rd_ff;
         head_ff <= head_sel;
      end else if (cmd.assign_ids) begin
         if (head_ff) begin
            if (need_s) vs_ff.head_cl <= CW'(id_s);
            if (need_d) vd_ff.head_cl <= CW'(id_d);
            else if (same_v && need_s) vd_ff.head_cl <= CW'(id_s);
         end else begin
            if (need_s) vs_ff.tail_cl <= CW'(id_s);
            if (need_d) vd_ff.tail_cl <= CW'(id_d);
            else if (same_v && need_s) vd_ff.tail_cl <= CW'(id_s);
            vs_ff.tail_degree <= sevc_pkg::sat_add(vs_ff.tail_degree,
                                                   same_v ? WW'(2) : WW'(1));
            vd_ff.tail_degree <= sevc_pkg::sat_add(vd_ff.tail_degree,
                                                   same_v ? WW'(2) : WW'(1));
         end
         mv_ff     <= need_s;
         mv_src_ff <= need_d;
      end else if (cmd.move && !same_c_ff) begin
         if (head_ff) begin
            if (h_src) vs_ff.head_cl <= vd_ff.head_cl;
            else if (h_dst) vd_ff.head_cl <= vs_ff.head_cl;
         end else if (t_move) begin
            if (t_src) vs_ff.tail_cl <= vd_ff.tail_cl;
            else vd_ff.tail_cl <= vs_ff.tail_cl;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_vol) begin
         cs_a_ff   <= cs_addr;
         cd_a_ff   <= cd_addr;
         same_c_ff <= same_c;
      end
   end

   // Cluster volumes: read, add newly assigned members (head) or the edge's endpoints (tail), then apply the move.
   always_comb begin
      cs_in = cs_ff;
      cd_in = cd_ff;
      if (cmd.rd_vol) begin
         cs_in = cs_rd_ff;
         cd_in = cd_rd_ff;
         if (head_ff) begin
            if (same_c) begin
               // Both endpoints can land in one cluster when fresh ids run out.
               cs_in.head_vol = sevc_pkg::sat_add(
                  sevc_pkg::sat_add(cs_rd_ff.head_vol, (mv_ff ? vs_ff.degree : '0)),
                  (mv_src_ff ? vd_ff.degree : '0));
               cd_in.head_vol = cs_in.head_vol;
            end else begin
               cs_in.head_vol = sevc_pkg::sat_add(cs_rd_ff.head_vol,
                  (mv_ff ? vs_ff.degree : '0));
               cd_in.head_vol = sevc_pkg::sat_add(cd_rd_ff.head_vol,
                  (mv_src_ff ? vd_ff.degree : '0));
            end
         end else begin
            if (same_c) begin
               cs_in.tail_vol = sevc_pkg::sat_add(cs_rd_ff.tail_vol, WW'(2));
               cd_in.tail_vol = sevc_pkg::sat_add(cs_rd_ff.tail_vol, WW'(2));
            end else begin
               cs_in.tail_vol = sevc_pkg::sat_add(cs_rd_ff.tail_vol, WW'(1));
               cd_in.tail_vol = sevc_pkg::sat_add(cd_rd_ff.tail_vol, WW'(1));
            end
         end
      end else if (cmd.move && !same_c_ff) begin
         if (head_ff) begin
            if (h_src) begin
               cs_in.head_vol = sevc_pkg::sat_sub(cs_ff.head_vol, vs_ff.degree);
               cd_in.head_vol = sevc_pkg::sat_add(cd_ff.head_vol, vs_ff.degree);
            end else if (h_dst) begin
               cd_in.head_vol = sevc_pkg::sat_sub(cd_ff.head_vol, vd_ff.degree);
               cs_in.head_vol = sevc_pkg::sat_add(cs_ff.head_vol, vd_ff.degree);
            end
         end else if (t_move) begin
            if (t_src) begin
               cd_in.tail_vol = sevc_pkg::sat_add(cd_ff.tail_vol, t_deg);
               cs_in.tail_vol = sevc_pkg::sat_sub(cs_ff.tail_vol, t_deg);
            end else begin
               cs_in.tail_vol = sevc_pkg::sat_add(cs_ff.tail_vol, t_deg);
               cd_in.tail_vol = sevc_pkg::sat_sub(cd_ff.tail_vol, t_deg);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cs_ff <= cs_in;
      cd_ff <= cd_in;
   end

   // Result register.
   logic is_read;
   assign is_read = (op_ff == sevc_pkg::OP_READ) && inr_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_edge_is_head      <= status.is_cluster && head_ff;
         rsp_src_cluster       <= !status.is_cluster ? sevc_pkg::CL_NONE :
                                  (head_ff ? vs_ff.head_cl : vs_ff.tail_cl);
         rsp_dst_cluster       <= !status.is_cluster ? sevc_pkg::CL_NONE :
                                  same_v ? (head_ff ? vs_ff.head_cl : vs_ff.tail_cl) :
                                  (head_ff ? vd_ff.head_cl : vd_ff.tail_cl);
         rsp_read_head_cluster <= is_read ? vs_ff.head_cl : sevc_pkg::CL_NONE;
         rsp_read_tail_cluster <= is_read ? vs_ff.tail_cl : sevc_pkg::CL_NONE;
         rsp_read_degree       <= is_read ? vs_ff.degree : '0;
      end
   end

endmodule

// ===== src/streaming_edge_vertex_clustering.sv =====
// Streaming edge vertex clustering: one edge or vertex transaction at a time. From one
// accepted request to the next ready, a read passes the vertex read and response steps, a
// degree update adds a degree write and a clustering step adds id assignment, volume read,
// move and write, set by the dependent read and write rounds of the vertex and cluster
// tables; a response that is not taken holds the block in its last step. After reset the
// tables are cleared one entry a cycle, so the first request is taken only once every entry is cleared.
`timescale 1ns / 1ps

module streaming_edge_vertex_clustering (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_operation,
   input  logic [15:0]          req_src_vertex,
   input  logic [15:0]          req_dst_vertex,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_edge_is_head,
   output logic signed [16:0]   rsp_src_cluster,
   output logic signed [16:0]   rsp_dst_cluster,
   output logic signed [16:0]   rsp_read_head_cluster,
   output logic signed [16:0]   rsp_read_tail_cluster,
   output logic [31:0]          rsp_read_degree,
   input  logic                 csr_write,
   input  logic                 csr_index,
   input  logic [31:0]          csr_data
);

   sevc_pkg::cmd_type    cmd;
   sevc_pkg::status_type status;

   sevc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sevc_datapath u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_operation         (req_operation),
      .req_src_vertex        (req_src_vertex),
      .req_dst_vertex        (req_dst_vertex),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .rsp_edge_is_head      (rsp_edge_is_head),
      .rsp_src_cluster       (rsp_src_cluster),
      .rsp_dst_cluster       (rsp_dst_cluster),
      .rsp_read_head_cluster (rsp_read_head_cluster),
      .rsp_read_tail_cluster (rsp_read_tail_cluster),
      .rsp_read_degree       (rsp_read_degree)
   );

endmodule
